// ===== hdl/irpb_pkg.sv =====
package irpb_pkg;

  localparam int DEF_STORE_DEPTH = 4096;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_FRAC_BITS   = 16;

  // Fixed register and field widths.
  localparam int LENGTH_W = 13;
  localparam int RATE_W   = 29;
  localparam int MODE_W   = 2;
  localparam int POKE_W   = 12;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 5;

  localparam logic [LENGTH_W-1:0] LENGTH_RST = LENGTH_W'(4096);

  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_RATE   = 3'd1,
    REG_MODE   = 3'd2,
    REG_PLAY   = 3'd3,
    REG_RECORD = 3'd4,
    REG_LOOP   = 3'd5
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEAREST = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_HERMITE = 2'd2,
    MODE_MUTE    = 2'd3
  } interp_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PMOD,
    ST_POKE,
    ST_REC,
    ST_IMOD,
    ST_READ,
    ST_PREP,
    ST_CALC,
    ST_ADV,
    ST_RMOD,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/irpb_mod.sv =====
// Restoring remainder unit: one conditional subtract per cycle, high shift first.
module irpb_mod #(
  parameter int VAL_W = 13,
  parameter int LEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  input  logic [LEN_W-1:0] len,
  output logic             done,
  output logic [LEN_W-1:0] rem
);

  localparam int W  = VAL_W + LEN_W;
  localparam int KW = (VAL_W > 1) ? $clog2(VAL_W) : 1;

  logic [VAL_W-1:0] v;
  logic [KW-1:0]    k;
  logic             busy;
  logic [W-1:0]     sub;
  logic             ge;

  assign sub = W'(len) << k;
  assign ge  = W'(v) >= sub;
  assign rem = v[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      k <= KW'(VAL_W - 1);
    end else if (busy) begin
      if (ge) begin
        v <= v - sub[VAL_W-1:0];
      end
      if (k != '0) begin
        k <= k - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/interpolating_record_playback_buffer.sv =====
// Looping record/playback store with fractional-rate, interpolated readout.
// Input stream (s_*): tuser carries the command (0 tick, 1 poke) and tdata
// carries the sample and the poke index. Every tick produces exactly one
// transfer on the output stream (m_*); a poke produces none.
// Registers sit on an APB port at byte addresses 0, 4, ..., 20.
// The block takes one item at a time. A poke runs the remainder unit on its
// index and then writes the store. A tick writes its sample while recording,
// then the restoring remainder unit gives the read index, the store delivers
// one word a cycle for the four taps, and the interpolation shares one
// multiplier over five Horner steps in the four-point mode. The advanced read
// position is wrapped by the remainder unit again, or by adding the length
// when it falls below zero. With playback off a tick goes straight to output.
// After reset the store is swept to zero, one word a cycle over all
// STORE_DEPTH words (4096 at the default size); no input transfer is accepted then.
// A finished result waits in the output register; the block goes on
// taking input while it waits and only stalls when a second tick result
// is ready before the first has been taken.
module interpolating_record_playback_buffer
  import irpb_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // sample_in [SAMPLE_BITS-1:0], poke_index above it, zero padded to bytes
  input  logic [((SAMPLE_BITS+POKE_W+7)/8)*8-1:0] s_tdata,
  // cmd [0]
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // sample_out [SAMPLE_BITS-1:0], zero padded to bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_AW-1:0]          paddr,
  input  logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int LW    = AW + 1;
  localparam int PW    = AW + FRAC_BITS;
  localparam int SW0   = PW + 2;
  localparam int SW    = (SW0 > RATE_W + 1) ? SW0 : RATE_W + 1;
  localparam int MVW0  = SW - 1 - FRAC_BITS;
  localparam int MVW   = (MVW0 > POKE_W) ? MVW0 : POKE_W;
  localparam int CW    = (LENGTH_W > LW) ? LENGTH_W : LW;
  localparam int ACC_W = SAMPLE_BITS + 10;
  localparam int MW    = ACC_W + FRAC_BITS + 1;
  localparam int ODW   = ((SAMPLE_BITS+7)/8)*8;

  // Configuration registers.
  logic [LENGTH_W-1:0]    buffer_length;
  logic [RATE_W-1:0]      playback_rate;
  logic [MODE_W-1:0]      interp_mode;
  logic                   play_enable;
  logic                   record_enable;
  logic                   rec_loop;

  // Playback state and datapath registers.
  state_t                 state, state_next;
  logic [AW-1:0]          clr_cnt;
  logic [LW-1:0]          write_position;
  logic [LW-1:0]          record_budget;
  logic [PW-1:0]          read_position;
  logic [SAMPLE_BITS-1:0] smp;
  logic [LW-1:0]          i0;
  logic [2:0]             rd_cnt;
  logic [2:0]             step;
  logic signed [SAMPLE_BITS-1:0] tap [4];
  logic signed [ACC_W-1:0] acc;
  logic [FRAC_BITS-1:0]   frac_hold;
  logic signed [SAMPLE_BITS-1:0] result;
  logic [SAMPLE_BITS-1:0] out_data;
  logic                   out_valid;

  // Sample store.
  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  logic                   mod_start;
  logic [MVW-1:0]         mod_val;
  logic                   mod_done;
  logic [LW-1:0]          mod_rem;

  logic                   cfg_wr;
  logic                   in_xfer;
  logic [LW-1:0]          len;
  logic [LW-1:0]          wp0;
  logic                   rec_now;
  logic [LW-1:0]          a_l1, a_h0, a_h1, a_mid, a_r;
  logic [FRAC_BITS-1:0]   frac;

  always_comb begin
    if (buffer_length == '0) begin
      len = LW'(1);
    end else if (CW'(buffer_length) > CW'(STORE_DEPTH)) begin
      len = LW'(STORE_DEPTH);
    end else begin
      len = LW'(buffer_length);
    end
  end

  assign frac    = read_position[FRAC_BITS-1:0];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign in_xfer = s_tvalid && s_tready;
  assign wp0     = (write_position >= len) ? '0 : write_position;
  assign rec_now = (record_budget != '0) && record_enable;

  // Tap addresses around the integer read index, each wrapped at the length.
  always_comb begin
    logic [LW-1:0] t;
    t     = i0 + 1'b1;
    a_h0  = (t >= len) ? t - len : t;
    t     = a_h0 + 1'b1;
    a_h1  = (t >= len) ? t - len : t;
    a_l1  = (i0 == '0) ? len - 1'b1 : i0 - 1'b1;
    a_r   = frac[FRAC_BITS-1] ? a_h0 : i0;
    a_mid = (interp_mode == MODE_NEAREST) ? a_r : i0;
  end

  // Configuration port.
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_LENGTH: prdata = CFG_DW'(buffer_length);
      REG_RATE:   prdata = CFG_DW'(playback_rate);
      REG_MODE:   prdata = CFG_DW'(interp_mode);
      REG_PLAY:   prdata = CFG_DW'(play_enable);
      REG_RECORD: prdata = CFG_DW'(record_enable);
      REG_LOOP:   prdata = CFG_DW'(rec_loop);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= LENGTH_RST;
      playback_rate <= RATE_W'(1) << FRAC_BITS;
      interp_mode   <= MODE_LINEAR;
      play_enable   <= 1'b1;
      record_enable <= 1'b1;
      rec_loop      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_LENGTH: buffer_length <= pwdata[LENGTH_W-1:0];
        REG_RATE:   playback_rate <= pwdata[RATE_W-1:0];
        REG_MODE:   interp_mode   <= pwdata[MODE_W-1:0];
        REG_PLAY:   play_enable   <= pwdata[0];
        REG_RECORD: record_enable <= pwdata[0];
        REG_LOOP:   rec_loop      <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  irpb_mod #(
    .VAL_W (MVW),
    .LEN_W (LW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_val),
    .len   (len),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Horner step: one shared multiplier by the fraction, rounded half up.
  logic signed [MW-1:0]    prod;
  logic signed [MW-1:0]    rnd_f, rnd_h;
  logic signed [ACC_W-1:0] d, e, l0x, l1x, h0x, h1x, coef, herm_next, final_val;

  assign l1x  = ACC_W'(tap[0]);
  assign l0x  = ACC_W'(tap[1]);
  assign h0x  = ACC_W'(tap[2]);
  assign h1x  = ACC_W'(tap[3]);
  assign d    = h0x - l0x;
  assign e    = l1x - h1x;
  assign prod = MW'(acc) * $signed({1'b0, frac});
  assign rnd_f = (prod + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd_h = (prod + (MW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);

  always_comb begin
    unique case (step)
      3'd0:    coef = -(ACC_W'(15) * d + ACC_W'(5) * e);
      3'd1:    coef = ACC_W'(9) * d + ACC_W'(3) * e;
      3'd2:    coef = h0x - (l0x <<< 1) + l1x;
      default: coef = h0x - l1x;
    endcase
    herm_next = coef + rnd_f[ACC_W-1:0];
    final_val = '0;
    unique case (interp_mode_t'(interp_mode))
      MODE_NEAREST: final_val = l0x;
      MODE_LINEAR:  final_val = l0x + rnd_f[ACC_W-1:0];
      MODE_HERMITE: final_val = l0x + rnd_h[ACC_W-1:0];
      MODE_MUTE:    final_val = '0;
    endcase
  end

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Read position advance: clamped signed step, wrap at length.
  logic signed [SW-1:0] lqm1, rate_x, rate_c, p_sum;
  assign lqm1   = (SW'(len) <<< FRAC_BITS) - SW'(1);
  assign rate_x = SW'($signed(playback_rate));
  always_comb begin
    rate_c = rate_x;
    if (rate_x > lqm1) begin
      rate_c = lqm1;
    end else if (rate_x < -lqm1) begin
      rate_c = -lqm1;
    end
    p_sum = SW'(read_position) + rate_c;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == AW'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_next = s_tuser ? ST_PMOD : ST_REC;
      ST_PMOD:  if (mod_done) state_next = ST_POKE;
      ST_POKE:  state_next = ST_IDLE;
      ST_REC:   state_next = play_enable ? ST_IMOD : ST_OUT;
      ST_IMOD:  if (mod_done) state_next = ST_READ;
      ST_READ:  if (rd_cnt == 3'd4) state_next = ST_PREP;
      ST_PREP:  state_next = ST_CALC;
      ST_CALC: begin
        if (interp_mode != MODE_HERMITE || step == 3'd4) state_next = ST_ADV;
      end
      ST_ADV:   state_next = p_sum[SW-1] ? ST_OUT : ST_RMOD;
      ST_RMOD:  if (mod_done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_tready  = 1'b0;
    mod_start = 1'b0;
    mod_val   = MVW'(s_tdata[SAMPLE_BITS +: POKE_W]);
    mem_we    = 1'b0;
    mem_waddr = wp0[AW-1:0];
    mem_wdata = smp;
    mem_raddr = a_l1[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        mod_start = s_tvalid && s_tuser;
      end
      ST_POKE: begin
        mem_we    = 1'b1;
        mem_waddr = mod_rem[AW-1:0];
      end
      ST_REC: begin
        mem_we    = rec_now;
        mod_start = play_enable;
        mod_val   = MVW'(read_position[PW-1:FRAC_BITS]);
      end
      ST_READ: begin
        unique case (rd_cnt)
          3'd0:    mem_raddr = a_l1[AW-1:0];
          3'd1:    mem_raddr = a_mid[AW-1:0];
          3'd2:    mem_raddr = a_h0[AW-1:0];
          default: mem_raddr = a_h1[AW-1:0];
        endcase
      end
      ST_ADV: begin
        mod_start = !p_sum[SW-1];
        mod_val   = MVW'(p_sum[SW-2:FRAC_BITS]);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      write_position <= '0;
      record_budget  <= LW'(STORE_DEPTH);
      read_position  <= '0;
      out_valid      <= 1'b0;
      rd_cnt         <= '0;
      step           <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      // A new result may replace the one taken in the same cycle.
      if (state == ST_OUT && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_REC: begin
          logic [LW-1:0] wp1;
          wp1 = write_position;
          if (rec_now) begin
            wp1 = wp0 + 1'b1;
            record_budget <= record_budget - 1'b1;
          end else if (rec_loop) begin
            record_budget <= len;
          end
          write_position <= (wp1 >= len) ? '0 : wp1;
          rd_cnt <= '0;
          step   <= '0;
        end
        ST_READ: rd_cnt <= rd_cnt + 1'b1;
        ST_CALC: step <= step + 1'b1;
        ST_ADV: begin
          if (p_sum[SW-1]) begin
            read_position <= PW'(p_sum + (SW'(len) <<< FRAC_BITS));
          end
        end
        ST_RMOD: begin
          if (mod_done) begin
            read_position <= {mod_rem[AW-1:0], frac_hold};
          end
        end
        default: ;
      endcase
      // Any write of record_enable reloads the budget.
      if (cfg_wr && reg_idx_t'(paddr[CFG_AW-1:2]) == REG_RECORD) begin
        record_budget <= len;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == ST_REC) begin
      result <= '0;
    end
    if (state == ST_IMOD && mod_done) begin
      i0 <= mod_rem;
    end
    if (state == ST_READ && rd_cnt != 3'd0) begin
      tap[rd_cnt[1:0] - 2'd1] <= mem_rdata;
    end
    if (state == ST_PREP) begin
      acc <= (interp_mode == MODE_HERMITE) ?
             ACC_W'(6) * d + ACC_W'(2) * e : d;
    end
    if (state == ST_CALC) begin
      acc <= herm_next;
      if (interp_mode != MODE_HERMITE || step == 3'd4) begin
        result <= sat(final_val);
      end
    end
    if (state == ST_ADV) begin
      frac_hold <= p_sum[FRAC_BITS-1:0];
    end
    if (state == ST_OUT && (!out_valid || m_tready)) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = ODW'(out_data);

endmodule
